@@ hdl/sparse_block_range_set_defines.svh @@
// ----------------------------------------------------------------------------
// Sparse block range set: assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_BLOCK_RANGE_SET_DEFINES_SVH
`define SPARSE_BLOCK_RANGE_SET_DEFINES_SVH

`ifndef SYNTHESIS
`define SBRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SBRS_ASSERT_ONEHOT0(lbl, vec, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec)) else $error(msg);
`else
`define SBRS_ASSERT(lbl, prop, msg)
`define SBRS_ASSERT_ONEHOT0(lbl, vec, msg)
`endif

`endif

@@ hdl/sbrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse block range set: package
// Status codes and the control and flag structs shared by the cells and top.
// ----------------------------------------------------------------------------
package sbrs_pkg;

  typedef enum logic [2:0] {
    SBRS_COVERED  = 3'd0,
    SBRS_EXTENDED = 3'd1,
    SBRS_MERGED   = 3'd2,
    SBRS_NEW      = 3'd3,
    SBRS_FULL     = 3'd4
  } sbrs_status_t;

  // Compare results that a cell latches when an index is presented.
  typedef struct packed {
    logic cov;  // index lies inside this range
    logic aft;  // index is the block just after this range
    logic bef;  // index is the block just before this range
    logic lt;   // range starts below the index
    logic gt;   // range starts above the index
  } sbrs_flags_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic eval;
    logic update;
    logic any_cov;
    logic any_aft;
    logic any_bef;
    logic merge;
    logic insert;
  } sbrs_ctrl_t;

endpackage

@@ hdl/sbrs_cell.sv @@
// ----------------------------------------------------------------------------
// Sparse block range set: range cell
// Holds one (start, length) slot, compares it against the broadcast index and
// takes its new contents from itself or a neighbor on the update cycle.
// ----------------------------------------------------------------------------
module sbrs_cell
  import sbrs_pkg::*;
#(
  parameter int IDX_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sbrs_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic             in_use,
  input  logic             prev_lt,
  input  logic [IDX_W-1:0] prev_start,
  input  logic [IDX_W:0]   prev_len,
  input  logic             next_bef,
  input  logic [IDX_W-1:0] next_start,
  input  logic [IDX_W:0]   next_len,
  output sbrs_flags_t      flags,
  output logic [IDX_W-1:0] start,
  output logic [IDX_W:0]   len,
  output logic             sel
);

  sbrs_flags_t      flags_r, flags_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W:0]   len_r, len_nxt;
  logic             sel_r, sel_nxt;
  logic [IDX_W:0]   idx_x, end_x, start_x;

  assign idx_x   = {1'b0, idx};
  assign start_x = {1'b0, start_r};
  assign end_x   = start_x + len_r;

  always_comb begin
    flags_nxt     = flags_r;
    flags_nxt.cov = in_use && (idx_x >= start_x) && (idx_x < end_x);
    flags_nxt.aft = in_use && (idx_x == end_x);
    flags_nxt.bef = in_use && ((idx_x + 1'b1) == start_x);
    flags_nxt.lt  = in_use && (start_x < idx_x);
    flags_nxt.gt  = in_use && (start_x > idx_x);
  end

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    sel_nxt   = sel_r;
    if (ctrl.update) begin
      sel_nxt = 1'b0;
      if (ctrl.any_cov) begin
        sel_nxt = flags_r.cov;
      end else if (ctrl.any_aft) begin
        if (flags_r.aft) begin
          // The range grows by the index; an upper neighbor that now touches it is absorbed.
          len_nxt = len_r + 1'b1 + (next_bef ? next_len : '0);
          sel_nxt = 1'b1;
        end else if (ctrl.merge && flags_r.gt) begin
          start_nxt = next_start;
          len_nxt   = next_len;
        end
      end else if (ctrl.any_bef) begin
        if (flags_r.bef) begin
          start_nxt = idx;
          len_nxt   = len_r + 1'b1;
          sel_nxt   = 1'b1;
        end
      end else if (ctrl.insert && !flags_r.lt) begin
        if (prev_lt) begin
          start_nxt = idx;
          len_nxt   = (IDX_W+1)'(1);
          sel_nxt   = 1'b1;
        end else begin
          start_nxt = prev_start;
          len_nxt   = prev_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      flags_r <= flags_nxt;
    end
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

  assign flags = flags_r;
  assign start = start_r;
  assign len   = len_r;
  assign sel   = sel_r;

endmodule

@@ hdl/sbrs_select.sv @@
// ----------------------------------------------------------------------------
// Sparse block range set: result select
// AND-OR reduction that picks the contents of the one selected cell.
// ----------------------------------------------------------------------------
module sbrs_select #(
  parameter int N = 64,
  parameter int W = 65
) (
  input  logic [N-1:0] sel,
  input  logic [W-1:0] data [N],
  output logic [W-1:0] y
);

  always_comb begin
    y = '0;
    for (int k = 0; k < N; k++) begin
      y = y | (data[k] & {W{sel[k]}});
    end
  end

endmodule

@@ hdl/sparse_block_range_set.sv @@
// ----------------------------------------------------------------------------
// Sparse block range set
// Sorted table of disjoint block ranges, one range per cell of a chain.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_RANGES disjoint, non-touching ranges sorted by
// start, one range in each cell of a chain. Each input beat marks one block
// index as a hole; the output beat reports whether the index was already
// covered, grew a range (possibly merging two), opened a new range, or was
// dropped because the table is full (start and length then read as zero).
// An item passes through the phases ST_IDLE, ST_UPD and ST_SEL: on the
// accept edge every cell compares its range against the index in parallel
// and latches its flags; in ST_UPD every cell loads its new contents from
// itself or from a neighbor (shifting down on a merge, up on an insert); in
// ST_SEL the selected cell's range is picked out into the output register.
// The input is ready again in the cycle after that, so no new item is taken
// before the last one is through; a result left waiting in the output
// register holds the next item in ST_SEL. There is no clearing pass: only
// cells below the count of ranges in use take part.
module sparse_block_range_set
  import sbrs_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int INDEX_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_block_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [INDEX_BITS-1:0] out_range_start,
  output logic [INDEX_BITS:0]   out_range_length,
  output logic [6:0]            out_ranges_in_use
);

`include "sparse_block_range_set_defines.svh"

  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam int PAIR_W = 2 * INDEX_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SEL
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  sbrs_status_t          status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_status_r, out_status_nxt;
  logic [INDEX_BITS-1:0] out_start_r, out_start_nxt;
  logic [INDEX_BITS:0]   out_len_r, out_len_nxt;
  logic [6:0]            out_used_r, out_used_nxt;

  logic                  in_accept;
  logic                  load_out;
  sbrs_ctrl_t            ctrl;
  logic [INDEX_BITS-1:0] idx_bus;
  logic [CNT_W+6:0]      count_ext;

  sbrs_flags_t           c_flags [MAX_RANGES];
  logic [INDEX_BITS-1:0] c_start [MAX_RANGES];
  logic [INDEX_BITS:0]   c_len   [MAX_RANGES];
  logic [PAIR_W-1:0]     c_pair  [MAX_RANGES];
  logic [MAX_RANGES-1:0] c_sel;
  logic [MAX_RANGES-1:0] cov_vec, aft_vec, bef_vec, merge_vec;
  logic [PAIR_W-1:0]     pick;

  assign in_ready  = (phase_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign load_out  = (phase_r == ST_SEL) && (!out_valid_r || out_ready);

  // During the accept cycle the cells compare against the live input;
  // afterwards they see the latched index.
  assign idx_bus = (phase_r == ST_IDLE) ? in_block_index : idx_r;

  // The chain of range cells. Cell 0 has no lower neighbor: it treats the
  // space below it as lying under the index so an insert can land there.
  for (genvar m = 0; m < MAX_RANGES; m++) begin : g_cell
    localparam logic [CNT_W-1:0] CellId = CNT_W'(m);
    logic                  use_m;
    logic                  prev_lt_m;
    logic [INDEX_BITS-1:0] prev_start_m, next_start_m;
    logic [INDEX_BITS:0]   prev_len_m, next_len_m;
    logic                  next_bef_m;

    assign use_m = (CellId < count_r);

    if (m == 0) begin : g_first
      assign prev_lt_m    = 1'b1;
      assign prev_start_m = '0;
      assign prev_len_m   = '0;
    end else begin : g_inner_lo
      assign prev_lt_m    = c_flags[m-1].lt;
      assign prev_start_m = c_start[m-1];
      assign prev_len_m   = c_len[m-1];
    end

    if (m == MAX_RANGES - 1) begin : g_last
      assign next_bef_m   = 1'b0;
      assign next_start_m = '0;
      assign next_len_m   = '0;
    end else begin : g_inner_hi
      assign next_bef_m   = c_flags[m+1].bef;
      assign next_start_m = c_start[m+1];
      assign next_len_m   = c_len[m+1];
    end

    sbrs_cell #(
      .IDX_W(INDEX_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .idx       (idx_bus),
      .in_use    (use_m),
      .prev_lt   (prev_lt_m),
      .prev_start(prev_start_m),
      .prev_len  (prev_len_m),
      .next_bef  (next_bef_m),
      .next_start(next_start_m),
      .next_len  (next_len_m),
      .flags     (c_flags[m]),
      .start     (c_start[m]),
      .len       (c_len[m]),
      .sel       (c_sel[m])
    );

    assign c_pair[m]    = {c_start[m], c_len[m]};
    assign cov_vec[m]   = c_flags[m].cov;
    assign aft_vec[m]   = c_flags[m].aft;
    assign bef_vec[m]   = c_flags[m].bef;
    // An upward extension that now touches the next range swallows it.
    assign merge_vec[m] = c_flags[m].aft && next_bef_m;
  end

  // Since ranges never touch, at most one cell can report each kind of hit,
  // and a cell that grows upward always wins over its upper neighbor.
  always_comb begin
    ctrl         = '0;
    ctrl.eval    = in_accept;
    ctrl.update  = (phase_r == ST_UPD);
    ctrl.any_cov = |cov_vec;
    ctrl.any_aft = |aft_vec;
    ctrl.any_bef = |bef_vec;
    ctrl.merge   = |merge_vec;
    ctrl.insert  = !ctrl.any_cov && !ctrl.any_aft && !ctrl.any_bef &&
                   (count_r < CNT_W'(MAX_RANGES));
  end

  sbrs_select #(
    .N(MAX_RANGES),
    .W(PAIR_W)
  ) u_select (
    .sel (c_sel),
    .data(c_pair),
    .y   (pick)
  );

  assign count_ext = {7'd0, count_r};

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_used_nxt   = out_used_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (phase_r)
      ST_IDLE: begin
        if (in_accept) begin
          idx_nxt   = in_block_index;
          phase_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (ctrl.any_cov) begin
          status_nxt = SBRS_COVERED;
        end else if (ctrl.any_aft && ctrl.merge) begin
          status_nxt = SBRS_MERGED;
          count_nxt  = count_r - 1'b1;
        end else if (ctrl.any_aft || ctrl.any_bef) begin
          status_nxt = SBRS_EXTENDED;
        end else if (ctrl.insert) begin
          status_nxt = SBRS_NEW;
          count_nxt  = count_r + 1'b1;
        end else begin
          status_nxt = SBRS_FULL;
        end
        phase_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (load_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = pick[PAIR_W-1 -: INDEX_BITS];
          out_len_nxt    = pick[INDEX_BITS:0];
          out_used_nxt   = count_ext[6:0];
          phase_nxt      = ST_IDLE;
        end
      end
      default: begin
        phase_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_range_start   = out_start_r;
  assign out_range_length  = out_len_r;
  assign out_ranges_in_use = out_used_r;

  `SBRS_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_RANGES), "count beyond table size")
  `SBRS_ASSERT_ONEHOT0(a_sel_onehot, c_sel, "more than one cell selected")
  `SBRS_ASSERT(a_accept_to_upd, in_accept |=> (phase_r == ST_UPD), "beat not processed")
  `SBRS_ASSERT(a_cov_keeps_count, (ctrl.update && ctrl.any_cov) |=> $stable(count_r), "count moved")
  `SBRS_ASSERT(a_hit_kind, !(ctrl.update && ctrl.any_cov && ctrl.any_aft), "covered and extended")

endmodule

@@ tb/sbrs_range_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse block range set: result checker
// Watches both channels and keeps its own sorted range table. Every accepted
// mark is turned into the expected result beat, and each result beat is
// compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sbrs_range_checker
  import sbrs_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int IDX_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [IDX_W-1:0] in_block_index,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       out_status,
  input  logic [IDX_W-1:0] out_range_start,
  input  logic [IDX_W:0]   out_range_length,
  input  logic [6:0]       out_ranges_in_use,
  output int               n_waiting,
  output int               n_errors
);

  localparam logic [63:0] LEN_MASK    = (64'd1 << (IDX_W + 1)) - 64'd1;
  localparam int          MAX_REPORTS = 30;

  typedef struct packed {
    sbrs_status_t     status;
    logic [IDX_W-1:0] start;
    logic [IDX_W:0]   length;
    logic [6:0]       in_use;
  } range_beat_t;

  logic [IDX_W-1:0] slot_start [SLOTS];
  logic [IDX_W:0]   slot_len   [SLOTS];
  int               slots_used;
  range_beat_t      pending_ranges [$];
  int               status_seen [5];
  int               peak_in_use;
  int               n_reports;

  // Removes one range and closes the hole behind it.
  function automatic void drop_slot(int pos);
    int k;
    for (k = pos; k + 1 < slots_used; k++) begin
      slot_start[k] = slot_start[k + 1];
      slot_len[k]   = slot_len[k + 1];
    end
    if (slots_used > 0) slots_used--;
  endfunction

  function automatic range_beat_t make_beat(sbrs_status_t st, logic [63:0] s,
                                            logic [63:0] l);
    range_beat_t beat;
    beat.status = st;
    beat.start  = s[IDX_W-1:0];
    beat.length = l[IDX_W:0];
    beat.in_use = slots_used[6:0];
    return beat;
  endfunction

  // Applies one mark to the table. The first range, in ascending order, that
  // holds the index or touches it from either side decides the outcome.
  function automatic range_beat_t mark_hole(logic [IDX_W-1:0] idx);
    logic [63:0] x, s, l, off, nxt, prv_s, prv_l;
    int          n, i, k, pos;
    x = idx;
    n = slots_used;
    for (i = 0; i < n; i++) begin
      s = slot_start[i];
      l = slot_len[i];
      if (x >= s) begin
        off = x - s;
        if (l > off) return make_beat(SBRS_COVERED, s, l);
        if (l == off) begin
          l           = (l + 64'd1) & LEN_MASK;
          slot_len[i] = l[IDX_W:0];
          if (i + 1 < n) begin
            nxt = slot_start[i + 1];
            if (nxt == s + l) begin
              prv_l       = slot_len[i + 1];
              l           = (l + prv_l) & LEN_MASK;
              slot_len[i] = l[IDX_W:0];
              drop_slot(i + 1);
              return make_beat(SBRS_MERGED, s, l);
            end
          end
          return make_beat(SBRS_EXTENDED, s, l);
        end
      end else if (x + 64'd1 == s) begin
        l             = (l + 64'd1) & LEN_MASK;
        slot_start[i] = idx;
        slot_len[i]   = l[IDX_W:0];
        if (i > 0) begin
          prv_s = slot_start[i - 1];
          prv_l = slot_len[i - 1];
          if (x == prv_s + prv_l) begin
            l               = (prv_l + l) & LEN_MASK;
            slot_len[i - 1] = l[IDX_W:0];
            drop_slot(i);
            return make_beat(SBRS_MERGED, prv_s, l);
          end
        end
        return make_beat(SBRS_EXTENDED, x, l);
      end
    end
    if (n >= SLOTS) return make_beat(SBRS_FULL, 64'd0, 64'd0);
    pos = 0;
    while (pos < n && slot_start[pos] < idx) pos++;
    for (k = n; k > pos; k--) begin
      slot_start[k] = slot_start[k - 1];
      slot_len[k]   = slot_len[k - 1];
    end
    slot_start[pos] = idx;
    slot_len[pos]   = 1;
    slots_used      = n + 1;
    return make_beat(SBRS_NEW, x, 64'd1);
  endfunction

  task automatic note_mismatch(string field, logic [63:0] want_v, logic [63:0] got_v);
    n_errors++;
    if (n_reports < MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
    n_reports++;
  endtask

  task automatic print_summary(int marks);
    $display("Marked %0d blocks: %0d covered, %0d extended, %0d merged, %0d new, %0d full.",
             marks, status_seen[SBRS_COVERED], status_seen[SBRS_EXTENDED],
             status_seen[SBRS_MERGED], status_seen[SBRS_NEW], status_seen[SBRS_FULL]);
    $display("Peak table occupancy %0d of %0d ranges.", peak_in_use, SLOTS);
  endtask

  always @(posedge clk) begin : watch
    range_beat_t want;
    if (!rst_n) begin
      slots_used = 0;
      pending_ranges.delete();
    end else begin
      // Results first: a mark accepted at this edge cannot have its result yet.
      if (out_valid && out_ready) begin
        if (pending_ranges.size() == 0) begin
          n_errors++;
          if (n_reports < MAX_REPORTS)
            $display("%0t: result beat with none expected, got status %0d start 0x%0h",
                     $time, out_status, out_range_start);
          n_reports++;
        end else begin
          want = pending_ranges.pop_front();
          if (out_status != want.status)
            note_mismatch("status", want.status, out_status);
          if (out_range_start != want.start)
            note_mismatch("range_start", want.start, out_range_start);
          if (out_range_length != want.length)
            note_mismatch("range_length", want.length, out_range_length);
          if (out_ranges_in_use != want.in_use)
            note_mismatch("ranges_in_use", want.in_use, out_ranges_in_use);
        end
      end
      if (in_valid && in_ready) begin
        want = mark_hole(in_block_index);
        pending_ranges.push_back(want);
        status_seen[want.status]++;
        if (slots_used > peak_in_use) peak_in_use = slots_used;
      end
    end
    n_waiting = pending_ranges.size();
  end

endmodule

@@ tb/tb_sparse_block_range_set.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse block range set: testbench top
// Drives marks into the range table and throttles the result side; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
// The run opens with a short directed list (lowest and highest index, growth
// in both directions, merges, marks that are already covered, alternating bit
// patterns). The random part then works in windows: a window of consecutive
// blocks first gets scattered marks, some just outside its edges, and then
// every block of it is marked in shuffled order, so that extends and merges
// from both sides are common and the window ends up as a single range. A few
// windows sit at the very top or bottom of the index space, and a few single
// marks land anywhere. At the end, marks scattered over the whole space fill
// the table, and further marks show the full case, a merge on a full table
// that frees a slot, and a new range taking that slot.
// ----------------------------------------------------------------------------
module tb_sparse_block_range_set;

  localparam int SLOTS          = 64;
  localparam int IDX_W          = 32;
  localparam int RESET_CYCLES   = 11;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOLD_AT_ITEM   = 500;
  localparam int PAUSE_AT_ITEM  = 1100;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 600000;
  // Two single-block ranges one block apart; the block between them is
  // marked only once the table is full.
  localparam logic [IDX_W-1:0] SPLIT_PAIR = 32'h4000_0000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [IDX_W-1:0] in_block_index;
  logic             out_valid;
  logic             out_ready;
  logic [2:0]       out_status;
  logic [IDX_W-1:0] out_range_start;
  logic [IDX_W:0]   out_range_length;
  logic [6:0]       out_ranges_in_use;

  int n_waiting;
  int n_errors;
  int n_sent;
  int cycle_count;
  bit hold_out;   // asks the result side for one long hold-off
  bit tx_burst;   // current window is sent back to back

  sparse_block_range_set #(
    .MAX_RANGES(SLOTS),
    .INDEX_BITS(IDX_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_range_start  (out_range_start),
    .out_range_length (out_range_length),
    .out_ranges_in_use(out_ranges_in_use)
  );

  sbrs_range_checker #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_range_start  (out_range_start),
    .out_range_length (out_range_length),
    .out_ranges_in_use(out_ranges_in_use),
    .n_waiting        (n_waiting),
    .n_errors         (n_errors)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sparse_block_range_set: done, errors");
      $finish;
    end
  end

  // Idle gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one mark and returns once it has been accepted. Inputs change on
  // the falling edge; acceptance is judged from the values seen at the rising
  // edge. With no gap the valid simply stays high and only the index changes.
  task automatic mark_block(logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_block_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Result side. Takes beats with random gaps, sometimes for long stretches
  // without any, and once holds off for a long time on request so that the
  // block backs up into its input while marks keep being offered.
  initial begin : result_side
    int gap;
    int steady;
    out_ready = 1'b0;
    steady    = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_out  = 1'b0;
        out_ready <= 1'b1;
      end else if (steady > 0) begin
        out_ready <= 1'b1;
        steady--;
      end else if ($urandom_range(0, 99) < 15) begin
        out_ready <= 1'b1;
        steady = $urandom_range(20, 200);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          // Ready stays low for the gap; the next pass decides again.
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int               w, r, j, k, tmp;
    int               perm [SLOTS];
    bit               hold_done, pause_done;
    logic [IDX_W-1:0] base;
    in_valid       = 1'b0;
    in_block_index = '0;
    rst_n          = 1'b0;
    tx_burst       = 1'b0;
    hold_out       = 1'b0;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part. Growth upward, a merge with the next range, and a mark
    // inside a range at the bottom of the index space.
    mark_block(32'd0);            // new range on an empty table
    mark_block(32'd0);            // already covered
    mark_block(32'd1);            // grows upward
    mark_block(32'd3);            // new range, one block gap
    mark_block(32'd2);            // grows and absorbs the next range
    mark_block(32'd1);            // inside a longer range
    // The highest index has no block after it.
    mark_block(32'hFFFF_FFFF);
    mark_block(32'hFFFF_FFFE);    // grows downward onto the top block
    mark_block(32'hFFFF_FFFD);
    // Downward growth in the middle, then a merge from below.
    mark_block(32'd200);
    mark_block(32'd199);
    mark_block(32'd197);
    mark_block(32'd198);
    // Alternating patterns and growth across the sign bit.
    mark_block(32'hAAAA_AAAA);
    mark_block(32'h5555_5555);
    mark_block(32'h7FFF_FFFF);
    mark_block(32'h8000_0000);
    mark_block(SPLIT_PAIR);
    mark_block(SPLIT_PAIR + 32'd2);

    // Random windows until the random budget is spent.
    while (n_sent < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        mark_block($urandom);
      end else begin
        w = ($urandom_range(0, 99) < 70) ? $urandom_range(16, 48) : $urandom_range(2, 15);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // Window ending at, or one short of, the last index.
          base = 32'hFFFF_FFFF - w + 1 - $urandom_range(0, 1);
        end else if (r < 14) begin
          base = $urandom_range(0, 3);
        end else begin
          base = $urandom;
        end
        // Scattered marks, including the blocks just outside the window.
        repeat (w) mark_block(base + $urandom_range(0, w + 1) - 1);
        // Every block of the window in shuffled order closes all the gaps.
        for (j = 0; j < w; j++) perm[j] = j;
        for (j = w - 1; j > 0; j--) begin
          k       = $urandom_range(0, j);
          tmp     = perm[j];
          perm[j] = perm[k];
          perm[k] = tmp;
        end
        for (j = 0; j < w; j++) mark_block(base + perm[j]);
      end
      if (!hold_done && n_sent >= HOLD_AT_ITEM) begin
        hold_out  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && n_sent >= PAUSE_AT_ITEM) begin
        // The input side goes quiet until every result has been taken.
        pause_done = 1'b1;
        @(negedge clk) in_valid <= 1'b0;
        while (n_waiting != 0) @(negedge clk);
      end
    end

    // Fill the table with scattered singles; the later ones find it full.
    tx_burst = 1'b0;
    repeat (80) mark_block($urandom);
    // Closing the split pair merges two ranges and frees one slot, which the
    // next scattered mark takes; after that the table is full again.
    mark_block(SPLIT_PAIR + 32'd1);
    mark_block($urandom);
    repeat (4) mark_block($urandom);
    mark_block(SPLIT_PAIR);

    @(negedge clk) in_valid <= 1'b0;
    while (n_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    i_checker.print_summary(n_sent);
    if (n_errors == 0 && n_waiting == 0) begin
      $display("tb_sparse_block_range_set: done, clean");
    end else begin
      $display("tb_sparse_block_range_set: done, errors");
    end
    $finish;
  end

endmodule
